// ----- design/oasf_pkg.sv -----
// Package for the overlap alignment score fill block.
// Holds beat types, cell link type, configuration type and direction codes.
// No dependencies.
`default_nettype none
package oasf_pkg;

    localparam int SYM_W   = 8;
    localparam int COL_W   = 6;
    localparam int SCORE_W = 16;
    localparam int WIDE_W  = 18;
    localparam int CFG_W   = 8;
    localparam int LEN_W   = 7;
    localparam int CIDX_W  = 2;
    localparam int CAP     = 64;

    localparam logic [1:0] DIR_DIAG = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_LEFT = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CIDX_W-1:0] REG_MATCH    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MISMATCH = 2'd1;
    localparam logic [CIDX_W-1:0] REG_GAP      = 2'd2;
    localparam logic [CIDX_W-1:0] REG_LENGTH   = 2'd3;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7fff;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;

    typedef struct packed {
        logic             kind;
        logic [SYM_W-1:0] symbol;
        logic [COL_W-1:0] load_index;
        logic             first_row;
    } t_in;

    typedef struct packed {
        logic [COL_W-1:0]          column;
        logic signed [SCORE_W-1:0] score;
        logic [1:0]                direction;
        logic                      last;
    } t_out;

    typedef struct packed {
        logic                      active;
        logic                      first;
        logic [SYM_W-1:0]          qsym;
        logic [COL_W-1:0]          col;
        logic signed [SCORE_W-1:0] diag;
        logic signed [SCORE_W-1:0] left;
    } t_link;

    typedef struct packed {
        logic signed [CFG_W-1:0] match_score;
        logic signed [CFG_W-1:0] mismatch_score;
        logic signed [CFG_W-1:0] gap_score;
        logic [COL_W-1:0]        last_col;
    } t_cfg;

endpackage
`default_nettype wire

// ----- design/oasf_cell.sv -----
// One column cell of the score fill chain.
// Holds the reference symbol and previous-row score of its column; uses oasf_pkg.
// Takes the row token from its left neighbor and hands it on through its link register.
`default_nettype none
module oasf_cell
    import oasf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_sym_we,
    input  wire logic [SYM_W-1:0] i_sym,
    input  wire t_cfg             i_cfg,
    input  wire t_link            i_link,
    output t_link                 o_link,
    output logic                  o_hit,
    output t_out                  o_res
);

    logic [SYM_W-1:0]          r_sym;
    logic signed [SCORE_W-1:0] r_prev;
    t_link                     r_link;
    t_link                     n_link;

    logic signed [SCORE_W-1:0] w_above;
    logic signed [WIDE_W-1:0]  w_diag;
    logic signed [WIDE_W-1:0]  w_up;
    logic signed [WIDE_W-1:0]  w_left;
    logic signed [WIDE_W-1:0]  w_best;
    logic signed [SCORE_W-1:0] w_sat;
    logic [1:0]                w_dir;
    logic                      w_last;

    always_comb begin
        w_above = i_link.first ? '0 : r_prev;
        w_diag  = WIDE_W'(i_link.diag) + WIDE_W'((r_sym == i_link.qsym) ?
                  i_cfg.match_score : i_cfg.mismatch_score);
        w_up    = WIDE_W'(w_above) + WIDE_W'(i_cfg.gap_score);
        w_left  = WIDE_W'(i_link.left) + WIDE_W'(i_cfg.gap_score);
        if (w_diag >= w_up) begin
            if (w_diag >= w_left) begin
                w_best = w_diag;
                w_dir  = DIR_DIAG;
            end else begin
                w_best = w_left;
                w_dir  = DIR_LEFT;
            end
        end else begin
            if (w_up >= w_left) begin
                w_best = w_up;
                w_dir  = DIR_UP;
            end else begin
                w_best = w_left;
                w_dir  = DIR_LEFT;
            end
        end
        if (w_best > WIDE_W'(SCORE_MAX)) begin
            w_sat = SCORE_MAX;
        end else if (w_best < WIDE_W'(SCORE_MIN)) begin
            w_sat = SCORE_MIN;
        end else begin
            w_sat = w_best[SCORE_W-1:0];
        end
        w_last = (i_link.col == i_cfg.last_col);
    end

    always_comb begin
        n_link        = r_link;
        if (i_adv) begin
            n_link.active = i_link.active && !w_last;
            n_link.first  = i_link.first;
            n_link.qsym   = i_link.qsym;
            n_link.col    = i_link.col + COL_W'(1);
            n_link.diag   = w_above;
            n_link.left   = w_sat;
        end
    end

    always_comb begin
        o_hit           = i_link.active;
        o_res           = '0;
        if (i_link.active) begin
            o_res.column    = i_link.col;
            o_res.score     = w_sat;
            o_res.direction = w_dir;
            o_res.last      = w_last;
        end
        o_link          = r_link;
    end

    always_ff @(posedge i_clk) begin
        if (i_sym_we) begin
            r_sym <= i_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_link <= '0;
        end else begin
            r_link <= n_link;
            if (i_adv && i_link.active) begin
                r_prev <= w_sat;
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/overlap_alignment_score_fill.sv -----
// Overlap alignment score fill: a load beat writes one reference symbol; a query
// beat fills one matrix row, one column per cycle unless the output stalls, as a
// token walks the cell chain. The next beat is taken once the last column's result
// has entered the output register. Stalls on the output hold the chain.
// Uses oasf_pkg and oasf_cell.
`default_nettype none
module overlap_alignment_score_fill
    import oasf_pkg::*;
#(
    parameter int MAX_LENGTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in               i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out                   o_out
);

    localparam int NCELL = (MAX_LENGTH < CAP) ? MAX_LENGTH : CAP;
    localparam logic [LEN_W-1:0] NCELL_LEN = LEN_W'(NCELL);

    logic signed [CFG_W-1:0] r_match;
    logic signed [CFG_W-1:0] r_mismatch;
    logic signed [CFG_W-1:0] r_gap;
    logic [LEN_W-1:0]        r_len;

    logic  r_busy;
    logic  n_busy;
    t_link r_link0;
    t_link n_link0;
    logic  r_out_valid;
    t_out  r_out;

    t_cfg  w_cfg;
    logic  w_adv;
    logic  w_acc;
    logic  w_hit_any;
    t_out  w_res;

    t_link w_link [0:NCELL];
    logic  w_hit  [0:NCELL-1];
    t_out  w_rout [0:NCELL-1];

    always_comb begin
        w_cfg.match_score    = r_match;
        w_cfg.mismatch_score = r_mismatch;
        w_cfg.gap_score      = r_gap;
        if (r_len == '0) begin
            w_cfg.last_col = '0;
        end else if (r_len > NCELL_LEN) begin
            w_cfg.last_col = COL_W'(NCELL_LEN - LEN_W'(1));
        end else begin
            w_cfg.last_col = COL_W'(r_len - LEN_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= 8'sd1;
            r_mismatch <= -8'sd1;
            r_gap      <= -8'sd2;
            r_len      <= LEN_W'(CAP);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MATCH:    r_match    <= i_cfg_data;
                REG_MISMATCH: r_mismatch <= i_cfg_data;
                REG_GAP:      r_gap      <= i_cfg_data;
                REG_LENGTH:   r_len      <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready  = !r_busy;
    assign w_acc       = i_in_valid && !r_busy;
    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        w_hit_any = 1'b0;
        w_res     = '0;
        for (int j = 0; j < NCELL; j++) begin
            w_hit_any = w_hit_any | w_hit[j];
            w_res     = w_res | w_rout[j];
        end
    end

    always_comb begin
        n_busy  = r_busy;
        n_link0 = r_link0;
        if (w_adv) begin
            n_link0.active = 1'b0;
            if (w_hit_any && w_res.last) begin
                n_busy = 1'b0;
            end
        end
        if (w_acc && i_in.kind == KIND_QUERY) begin
            n_busy         = 1'b1;
            n_link0.active = 1'b1;
            n_link0.first  = i_in.first_row;
            n_link0.qsym   = i_in.symbol;
            n_link0.col    = '0;
            n_link0.diag   = '0;
            n_link0.left   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_link0     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_link0 <= n_link0;
            if (w_adv) begin
                r_out_valid <= w_hit_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_hit_any) begin
            r_out <= w_res;
        end
    end

    assign w_link[0] = r_link0;

    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        logic w_we;
        assign w_we = w_acc && (i_in.kind == KIND_LOAD) && (i_in.load_index == COL_W'(j));
        oasf_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_sym_we (w_we),
            .i_sym    (i_in.symbol),
            .i_cfg    (w_cfg),
            .i_link   (w_link[j]),
            .o_link   (w_link[j+1]),
            .o_hit    (w_hit[j]),
            .o_res    (w_rout[j])
        );
    end

endmodule
`default_nettype wire

// ----- dv/overlap_alignment_score_fill_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for overlap_alignment_score_fill: directed table, then random phases.
// Predicts every score cell of each query row and checks it against the output channel.
// Depends on oasf_pkg and the overlap_alignment_score_fill RTL.
module overlap_alignment_score_fill_tb;
    import oasf_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES = 100;
    localparam int NUM_STEPS = 27;

    typedef enum logic [1:0] {STEP_BEAT, STEP_CHECKED, STEP_REG} t_step_kind;

    typedef struct packed {
        t_step_kind        op;
        t_in               beat;
        t_out              want;
        logic [CIDX_W-1:0] sel;
        logic [CFG_W-1:0]  data;
    } t_step;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    t_in               in_beat = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out              out_beat;

    logic signed [CFG_W-1:0] cfg_match = 8'sd1;
    logic signed [CFG_W-1:0] cfg_mismatch = -8'sd1;
    logic signed [CFG_W-1:0] cfg_gap = -8'sd2;
    logic [LEN_W-1:0]        cfg_length = 7'd64;
    logic [SYM_W-1:0]        ref_symbol [CAP];
    int                      row_score [CAP];
    logic [SYM_W-1:0]        alphabet [4];

    t_out  expected_cells [$];
    t_step steps [NUM_STEPS];
    int    send_idle = 0;
    int    recv_idle = 0;
    int    error_count = 0;
    int    quiet_cycles = 0;
    int    load_count = 0;
    int    row_count = 0;
    int    checked_count = 0;
    int    sat_count = 0;
    int    dir_count [3] = '{0, 0, 0};

    overlap_alignment_score_fill i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic t_step reg_step(input logic [CIDX_W-1:0] sel, input logic [CFG_W-1:0] data);
        t_step s;
        s = '0;
        s.op = STEP_REG;
        s.sel = sel;
        s.data = data;
        return s;
    endfunction

    function automatic t_step load_step(input logic [COL_W-1:0] idx, input logic [SYM_W-1:0] sym);
        t_step s;
        s = '0;
        s.op = STEP_BEAT;
        s.beat.kind = KIND_LOAD;
        s.beat.symbol = sym;
        s.beat.load_index = idx;
        return s;
    endfunction

    function automatic t_step query_step(input logic [SYM_W-1:0] sym, input logic first);
        t_step s;
        s = '0;
        s.op = STEP_BEAT;
        s.beat.kind = KIND_QUERY;
        s.beat.symbol = sym;
        s.beat.first_row = first;
        return s;
    endfunction

    // single-column row: the result is column 0 with last set
    function automatic t_step check_step(input logic [SYM_W-1:0] sym, input logic first,
                                         input int score, input logic [1:0] dir);
        t_step s;
        s = query_step(sym, first);
        s.op = STEP_CHECKED;
        s.want.column = '0;
        s.want.score = SCORE_W'(score);
        s.want.direction = dir;
        s.want.last = 1'b1;
        return s;
    endfunction

    task automatic fill_row(input t_in b);
        int cols, above, diag, up, lft, best, diag_prev, left_cur;
        logic [1:0] dir;
        t_out pred;
        if (b.kind == KIND_LOAD) begin
            ref_symbol[b.load_index] = b.symbol;
            load_count++;
            return;
        end
        cols = int'(cfg_length);
        if (cols == 0) cols = 1;
        if (cols > CAP) cols = CAP;
        diag_prev = 0;
        left_cur = 0;
        for (int j = 0; j < cols; j++) begin
            above = b.first_row ? 0 : row_score[j];
            diag = diag_prev + ((ref_symbol[j] == b.symbol) ? int'(cfg_match) : int'(cfg_mismatch));
            up = above + int'(cfg_gap);
            lft = left_cur + int'(cfg_gap);
            if (diag >= up) begin
                if (diag >= lft) begin
                    best = diag;
                    dir = DIR_DIAG;
                end else begin
                    best = lft;
                    dir = DIR_LEFT;
                end
            end else if (up >= lft) begin
                best = up;
                dir = DIR_UP;
            end else begin
                best = lft;
                dir = DIR_LEFT;
            end
            if (best > 32767) best = 32767;
            else if (best < -32768) best = -32768;
            if (best == 32767) sat_count++;
            dir_count[dir]++;
            diag_prev = above;
            left_cur = best;
            row_score[j] = best;
            pred.column = COL_W'(j);
            pred.score = SCORE_W'(best);
            pred.direction = dir;
            pred.last = (j == cols - 1);
            expected_cells.push_back(pred);
        end
        row_count++;
    endtask

    task automatic check_cell(input t_out got);
        t_out want;
        if (expected_cells.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("unexpected beat: column %0d score %0d direction %0d last %0d",
                         got.column, got.score, got.direction, got.last);
            return;
        end
        want = expected_cells.pop_front();
        checked_count++;
        if (got.column !== want.column || got.score !== want.score ||
            got.direction !== want.direction || got.last !== want.last) begin
            error_count++;
            if (error_count <= 10)
                $display("mismatch: column %0d/%0d score %0d/%0d direction %0d/%0d last %0d/%0d",
                         want.column, got.column, want.score, got.score,
                         want.direction, got.direction, want.last, got.last);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) check_cell(out_beat);
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] sel, input logic [CFG_W-1:0] data);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (sel)
            REG_MATCH: cfg_match = data;
            REG_MISMATCH: cfg_mismatch = data;
            REG_GAP: cfg_gap = data;
            REG_LENGTH: cfg_length = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] mm,
                              input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] len);
        write_reg(REG_MATCH, m);
        write_reg(REG_MISMATCH, mm);
        write_reg(REG_GAP, g);
        write_reg(REG_LENGTH, len);
    endtask

    task automatic send_beat(input t_in b, input logic typed, input t_out want);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        do @(posedge clk); while (!in_ready);
        fill_row(b);
        if (typed) begin
            void'(expected_cells.pop_back());
            expected_cells.push_back(want);
        end
    endtask

    function automatic t_in random_beat();
        t_in b;
        b.kind = ($urandom_range(99) < 15) ? KIND_LOAD : KIND_QUERY;
        b.symbol = ($urandom_range(3) == 0) ? SYM_W'($urandom) : alphabet[$urandom_range(3)];
        b.load_index = COL_W'($urandom);
        b.first_row = ($urandom_range(9) == 0);
        return b;
    endfunction

    task automatic reload_symbols();
        t_in b;
        foreach (alphabet[k]) alphabet[k] = SYM_W'($urandom);
        for (int i = 0; i < CAP; i++) begin
            b.kind = KIND_LOAD;
            b.symbol = alphabet[$urandom_range(3)];
            b.load_index = COL_W'(i);
            b.first_row = 1'($urandom);
            send_beat(b, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] mm,
                             input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] len,
                             input int count);
        set_config(m, mm, g, len);
        repeat (count) begin
            send_beat(random_beat(), 1'b0, '0);
            if ($urandom_range(29) == 0) drain();
        end
    endtask

    task automatic saturate_rows(input int count);
        t_in b;
        set_config(8'h7F, 8'h7F, 8'h7F, 8'd64);
        for (int r = 0; r < count; r++) begin
            b.kind = KIND_QUERY;
            b.symbol = SYM_W'($urandom);
            b.load_index = COL_W'($urandom);
            b.first_row = (r == 0);
            send_beat(b, 1'b0, '0);
        end
    endtask

    initial begin
        foreach (row_score[k]) row_score[k] = 0;
        foreach (ref_symbol[k]) ref_symbol[k] = '0;
        steps = '{
            reg_step(REG_LENGTH, 8'd0),
            load_step(6'd0, 8'h00),
            check_step(8'h00, 1'b1, 1, DIR_DIAG),
            check_step(8'hFF, 1'b0, -1, DIR_DIAG),
            check_step(8'h00, 1'b0, 1, DIR_DIAG),
            reg_step(REG_GAP, 8'h7F),
            check_step(8'hFF, 1'b0, 128, DIR_UP),
            check_step(8'hFF, 1'b1, 127, DIR_UP),
            reg_step(REG_GAP, 8'h80),
            check_step(8'h00, 1'b1, 1, DIR_DIAG),
            reg_step(REG_MISMATCH, 8'h80),
            reg_step(REG_GAP, 8'hFF),
            check_step(8'hFF, 1'b1, -1, DIR_UP),
            check_step(8'hFF, 1'b0, -1, DIR_LEFT),
            reg_step(REG_MATCH, 8'h80),
            check_step(8'h00, 1'b0, -1, DIR_LEFT),
            reg_step(REG_MATCH, 8'h7F),
            reg_step(REG_MISMATCH, 8'h7F),
            check_step(8'hFF, 1'b1, 127, DIR_DIAG),
            reg_step(REG_LENGTH, 8'd4),
            load_step(6'd1, 8'hFF),
            load_step(6'd2, 8'hA5),
            load_step(6'd3, 8'h3C),
            load_step(6'd63, 8'h81),
            query_step(8'hA5, 1'b0),
            query_step(8'h3C, 1'b0),
            query_step(8'hFF, 1'b1)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_idle = 32;
        recv_idle = 58;
        foreach (steps[i]) begin
            case (steps[i].op)
                STEP_REG: write_reg(steps[i].sel, steps[i].data);
                STEP_CHECKED: send_beat(steps[i].beat, 1'b1, steps[i].want);
                default: send_beat(steps[i].beat, 1'b0, '0);
            endcase
        end

        reload_symbols();
        run_phase(8'h02, 8'hFF, 8'hFE, 8'd9, 40);
        run_phase(8'h7F, 8'h80, 8'h80, 8'd200, 40);

        send_idle = 58;
        recv_idle = 32;
        run_phase(8'h80, 8'h7F, 8'h7F, 8'd65, 40);
        run_phase(8'hFD, 8'h05, 8'h00, 8'd128, 40);

        send_idle = 0;
        recv_idle = 0;
        saturate_rows(210);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        error_count += expected_cells.size();

        $display("Covered %0d reference loads and %0d query rows; %0d result beats compared.",
                 load_count, row_count, checked_count);
        $display("Directions diagonal %0d, up %0d, left %0d; %0d saturated scores.",
                 dir_count[DIR_DIAG], dir_count[DIR_UP], dir_count[DIR_LEFT], sat_count);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/oasf_pkg.sv
design/oasf_cell.sv
design/overlap_alignment_score_fill.sv
dv/overlap_alignment_score_fill_tb.sv
